/* rtl/mset_pkg.sv */
// Package for the multi-slot event timer: sizes, command and result codes,
// and the structs passed between the top level and the slot cells.
// No dependencies.
`default_nettype none
package mset_pkg;

  localparam int SLOTS  = 8;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 4;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_SCHEDULE   = 3'd1,
    CMD_OSCILLATE  = 3'd2,
    CMD_REMOVE     = 3'd3,
    CMD_REMOVE_ALL = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_SCHED_ACK  = 3'd0,
    KIND_FIRE       = 3'd1,
    KIND_TICK_DONE  = 3'd2,
    KIND_REMOVE_ACK = 3'd3,
    KIND_RMALL_ACK  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // Contents of one timer slot.
  typedef struct packed {
    logic [31:0]        period;
    logic [31:0]        due;
    logic signed [16:0] reps;
    logic               osc;
    logic [7:0]         pin;
    logic               level;
  } slot_rec_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic wr;     // store a new slot record
    logic clr;    // free the slot
    logic shift;  // move the walk token one cell on
    logic adv;    // evaluate the cell holding the token
  } cell_ctl_t;

  // Per-cell status back to the sequencer.
  typedef struct packed {
    logic       used;
    logic       tok;
    logic       fire;
    logic       osc;
    logic [7:0] pin;
    logic       level;
  } cell_sts_t;

  // One result item.
  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic               ok;
    logic               osc;
    logic [7:0]         pin;
    logic               level;
    logic [CNT_W-1:0]   cnt;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

/* rtl/mset_cell.sv */
// One timer slot cell: holds a slot record and the walk token it passes on.
// Depends on mset_pkg.
`default_nettype none
module mset_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mset_pkg::cell_ctl_t ctl,
  input  wire mset_pkg::slot_rec_t wr_rec,
  input  wire logic                tok_in,
  input  wire logic [31:0]         now_ms,
  output mset_pkg::cell_sts_t      sts
);
  import mset_pkg::*;

  logic               used_r, used_nxt;
  logic               tok_r, tok_nxt;
  slot_rec_t          rec_r, rec_nxt;
  logic               hit;
  logic signed [16:0] reps_dec;

  // The cell holding the token fires when its slot is used and due.
  assign hit      = tok_r && ctl.adv && used_r && (now_ms >= rec_r.due);
  assign reps_dec = (rec_r.reps > 17'sd0) ? rec_r.reps - 17'sd1 : rec_r.reps;

  // Slot update on store, removal and firing.
  always_comb begin
    used_nxt = used_r;
    rec_nxt  = rec_r;
    tok_nxt  = ctl.shift ? tok_in : tok_r;
    if (ctl.wr) begin
      used_nxt = 1'b1;
      rec_nxt  = wr_rec;
    end else if (ctl.clr) begin
      used_nxt = 1'b0;
    end else if (hit) begin
      rec_nxt.reps = reps_dec;
      if (rec_r.osc) begin
        rec_nxt.level = ~rec_r.level;
      end
      if (reps_dec == 17'sd0) begin
        used_nxt = 1'b0;
      end else begin
        rec_nxt.due = rec_r.due + rec_r.period;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      tok_r  <= tok_nxt;
    end
    rec_r <= rec_nxt;
  end

  assign sts.used  = used_r;
  assign sts.tok   = tok_r;
  assign sts.fire  = hit;
  assign sts.osc   = rec_r.osc;
  assign sts.pin   = rec_r.osc ? rec_r.pin : 8'd0;
  assign sts.level = rec_r.osc ? rec_r.level : 1'b0;

endmodule
`default_nettype wire

/* rtl/multi_slot_event_timer.sv */
// Multi-slot event timer top level: command decode, walk sequencer and the
// output register around a chain of slot cells. Depends on mset_pkg, mset_cell.
//
// Eight timer slots sit in a row of cells. Schedule, oscillate, remove and
// remove-all commands each give one result. A tick walks a token down the
// cell row, one slot per cycle, emitting a fire result for each due slot
// and then a tick-done result; the walk pauses whenever the output register
// is full and not being taken. A new command is taken only when the walk is
// finished and the output register can accept a result.
`default_nettype none
module multi_slot_event_timer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // cmd[2:0], period_ms[34:3], repeats[50:35], first_delay[82:51],
  // pin_number[90:83], start_level[91], slot_sel[94:92], zero fill above
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // slot_out[2:0], ok[3], is_osc[4], pin_out[12:5], level_out[13],
  // count[17:14], zero fill above
  output logic [23:0]      out_tdata,
  // kind[2:0]
  output logic [2:0]       out_tuser,
  output logic             out_tlast
);
  import mset_pkg::*;

  // Input field split.
  cmd_t               cmd;
  logic [31:0]        period;
  logic signed [15:0] repeats;
  logic signed [31:0] delay;
  logic [7:0]         pin;
  logic               lvl;
  logic [SLOT_W-1:0]  sel;

  assign cmd     = cmd_t'(in_tdata[2:0]);
  assign period  = in_tdata[34:3];
  assign repeats = in_tdata[50:35];
  assign delay   = in_tdata[82:51];
  assign pin     = in_tdata[90:83];
  assign lvl     = in_tdata[91];
  assign sel     = in_tdata[94:92];

  state_t           state_r, state_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;

  cell_ctl_t  ctl [SLOTS];
  cell_sts_t  sts [SLOTS];
  logic [SLOTS-1:0] tok_vec;
  slot_rec_t  wr_rec;

  logic can_load, in_fire, start, adv, load;
  logic [SLOTS:0]    found;
  logic [SLOTS-1:0]  take;
  logic [SLOT_W-1:0] free_idx;
  logic [CNT_W-1:0]  used_cnt;
  logic [31:0]       sum;
  res_t              fire_res;
  logic              any_fire;

  assign can_load = !out_valid_r || out_tready;
  assign in_fire  = in_tvalid && in_tready;

  // Slot cell chain; the walk token enters at cell 0.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic tok_in;
    if (g == 0) begin : g_first
      assign tok_in = start;
    end else begin : g_next
      assign tok_in = sts[g-1].tok;
    end
    mset_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl[g]),
      .wr_rec (wr_rec),
      .tok_in (tok_in),
      .now_ms (now_r),
      .sts    (sts[g])
    );
    assign tok_vec[g] = sts[g].tok;
  end

  // Lowest free slot, count of used slots and the firing cell's report.
  always_comb begin
    found[0] = 1'b0;
    free_idx = '0;
    used_cnt = '0;
    any_fire = 1'b0;
    fire_res = '0;
    for (int i = 0; i < SLOTS; i++) begin
      take[i]    = !sts[i].used && !found[i];
      found[i+1] = found[i] || !sts[i].used;
      if (take[i]) begin
        free_idx = free_idx | SLOT_W'(i);
      end
      used_cnt = used_cnt + CNT_W'(sts[i].used);
      if (sts[i].fire) begin
        any_fire       = 1'b1;
        fire_res.slot  = fire_res.slot | SLOT_W'(i);
        fire_res.osc   = fire_res.osc | sts[i].osc;
        fire_res.pin   = fire_res.pin | sts[i].pin;
        fire_res.level = fire_res.level | sts[i].level;
      end
    end
    fire_res.kind = KIND_FIRE;
    fire_res.ok   = 1'b1;
  end

  // New slot record for schedule and oscillate.
  always_comb begin
    sum = now_r + (delay[31] ? period : 32'(unsigned'(delay)));
    wr_rec.period = period;
    wr_rec.due    = (sum == 32'd0) ? now_r : sum;
    wr_rec.osc    = (cmd == CMD_OSCILLATE);
    wr_rec.reps   = (cmd == CMD_OSCILLATE) ? {repeats, 1'b0} : {repeats[15], repeats};
    wr_rec.pin    = (cmd == CMD_OSCILLATE) ? pin : 8'd0;
    wr_rec.level  = (cmd == CMD_OSCILLATE) ? lvl : 1'b0;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire && cmd == CMD_TICK) state_nxt = ST_WALK;
      ST_WALK: if (can_load && sts[SLOTS-1].tok) state_nxt = ST_DONE;
      ST_DONE: if (can_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, cell control and the result to load.
  always_comb begin
    in_tready = (state_r == ST_IDLE) && can_load;
    start     = in_fire && (cmd == CMD_TICK);
    adv       = (state_r == ST_WALK) && can_load;
    load      = 1'b0;
    res_nxt   = '0;
    res_nxt.last = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      ctl[i].wr    = 1'b0;
      ctl[i].clr   = 1'b0;
      ctl[i].shift = start || adv;
      ctl[i].adv   = adv;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority case (cmd)
            CMD_SCHEDULE, CMD_OSCILLATE: begin
              load         = 1'b1;
              res_nxt.kind = KIND_SCHED_ACK;
              res_nxt.ok   = found[SLOTS];
              res_nxt.slot = found[SLOTS] ? free_idx : '0;
              for (int i = 0; i < SLOTS; i++) ctl[i].wr = take[i];
            end
            CMD_REMOVE: begin
              load         = 1'b1;
              res_nxt.kind = KIND_REMOVE_ACK;
              res_nxt.slot = sel;
              res_nxt.ok   = sts[sel].used;
              res_nxt.cnt  = CNT_W'(sts[sel].used);
              ctl[sel].clr = 1'b1;
            end
            CMD_REMOVE_ALL: begin
              load         = 1'b1;
              res_nxt.kind = KIND_RMALL_ACK;
              res_nxt.ok   = 1'b1;
              res_nxt.cnt  = used_cnt;
              for (int i = 0; i < SLOTS; i++) ctl[i].clr = 1'b1;
            end
            default: load = 1'b0;
          endcase
        end
      end
      ST_WALK: begin
        load    = adv && any_fire;
        res_nxt = fire_res;
      end
      ST_DONE: begin
        load         = can_load;
        res_nxt.kind = KIND_TICK_DONE;
        res_nxt.ok   = 1'b1;
        res_nxt.cnt  = cnt_r;
      end
      default: load = 1'b0;
    endcase
  end

  // Time, fire count and output register.
  always_comb begin
    now_nxt = start ? now_r + 32'd1 : now_r;
    cnt_nxt = start ? '0 : ((adv && any_fire) ? cnt_r + CNT_W'(1) : cnt_r);
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {6'd0, res_r.cnt, res_r.level, res_r.pin, res_r.osc, res_r.ok,
                       res_r.slot};

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec)) else $error("more than one walk token");
  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (tok_vec == '0)) else $error("token outside walk");
  a_walk_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> $onehot(tok_vec)) else $error("walk lost its token");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS)) else $error("fire count overflow");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb_multi_slot_event_timer.sv */
// Self-checking testbench for the multi-slot event timer: a directed table of
// commands, then random slot traffic, checked against a behavioral timer table.
// Depends on mset_pkg and multi_slot_event_timer.
`default_nettype none
module tb_multi_slot_event_timer;
  import mset_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] period;
    logic [15:0] reps;
    logic [31:0] delay;
    logic [7:0]  pin;
    logic        lvl;
    logic [2:0]  sel;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot;
    logic       ok;
    logic       osc;
    logic [7:0] pin;
    logic       level;
    logic [3:0] cnt;
    logic       last;
  } timer_res_t;

  // Directed row: command plus an optional typed-in first result.
  typedef struct {
    cmd_item_t  item;
    bit         has_exp;
    timer_res_t exp_res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  multi_slot_event_timer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Behavioral copy of the timer table.
  logic [31:0]        tm_now;
  logic               tm_used [SLOTS];
  logic [31:0]        tm_period [SLOTS];
  logic [31:0]        tm_due [SLOTS];
  logic signed [16:0] tm_reps [SLOTS];
  logic               tm_osc [SLOTS];
  logic [7:0]         tm_pin [SLOTS];
  logic               tm_level [SLOTS];

  timer_res_t pending_results[$];
  int  fail_cnt = 0;
  int  idle_cycles = 0;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;

  function automatic timer_res_t mk_res(logic [2:0] k, logic [2:0] s, logic ok,
                                        logic o, logic [7:0] p, logic l,
                                        logic [3:0] c, logic lst);
    timer_res_t r;
    r = '{kind: k, slot: s, ok: ok, osc: o, pin: p, level: l, cnt: c, last: lst};
    return r;
  endfunction

  // Apply one command to the table and queue the results it causes.
  task automatic predict_timer(input cmd_item_t it);
    logic [3:0]  fired;
    int          free_slot;
    logic [31:0] due;
    fired = 0;
    free_slot = -1;
    case (it.cmd)
      CMD_TICK: begin
        tm_now = tm_now + 1;
        for (int i = 0; i < SLOTS; i++) begin
          if (tm_used[i] && tm_now >= tm_due[i]) begin
            pending_results.push_back(mk_res(KIND_FIRE, i[2:0], 1'b1, tm_osc[i],
              tm_osc[i] ? tm_pin[i] : 8'd0, tm_osc[i] ? tm_level[i] : 1'b0,
              4'd0, 1'b0));
            fired++;
            if (tm_osc[i]) tm_level[i] = ~tm_level[i];
            if (tm_reps[i] > 0) tm_reps[i] = tm_reps[i] - 1;
            if (tm_reps[i] == 0) tm_used[i] = 1'b0;
            else tm_due[i] = tm_due[i] + tm_period[i];
          end
        end
        pending_results.push_back(mk_res(KIND_TICK_DONE, 3'd0, 1'b1, 1'b0, 8'd0,
                                         1'b0, fired, 1'b1));
      end
      CMD_SCHEDULE, CMD_OSCILLATE: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!tm_used[i]) free_slot = i;
        if (free_slot >= 0) begin
          due = tm_now + ($signed(it.delay) >= 0 ? it.delay : it.period);
          if (due == 0) due = tm_now;
          tm_used[free_slot]   = 1'b1;
          tm_period[free_slot] = it.period;
          tm_due[free_slot]    = due;
          tm_osc[free_slot]    = (it.cmd == CMD_OSCILLATE);
          tm_reps[free_slot]   = (it.cmd == CMD_OSCILLATE) ?
                                 17'($signed(it.reps)) * 2 : 17'($signed(it.reps));
          tm_pin[free_slot]    = (it.cmd == CMD_OSCILLATE) ? it.pin : 8'd0;
          tm_level[free_slot]  = (it.cmd == CMD_OSCILLATE) ? it.lvl : 1'b0;
          pending_results.push_back(mk_res(KIND_SCHED_ACK, 3'(free_slot), 1'b1,
                                           1'b0, 8'd0, 1'b0, 4'd0, 1'b1));
        end else begin
          pending_results.push_back(mk_res(KIND_SCHED_ACK, 3'd0, 1'b0, 1'b0, 8'd0,
                                           1'b0, 4'd0, 1'b1));
        end
      end
      CMD_REMOVE: begin
        logic hit;
        hit = tm_used[it.sel];
        tm_used[it.sel] = 1'b0;
        pending_results.push_back(mk_res(KIND_REMOVE_ACK, it.sel, hit, 1'b0, 8'd0,
                                         1'b0, {3'd0, hit}, 1'b1));
      end
      CMD_REMOVE_ALL: begin
        for (int i = 0; i < SLOTS; i++) if (tm_used[i]) begin
          tm_used[i] = 1'b0;
          fired++;
        end
        pending_results.push_back(mk_res(KIND_RMALL_ACK, 3'd0, 1'b1, 1'b0, 8'd0,
                                         1'b0, fired, 1'b1));
      end
      default: ;
    endcase
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall and result checking.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        timer_res_t got, exp_r;
        got = mk_res(out_tuser, out_tdata[2:0], out_tdata[3], out_tdata[4],
                     out_tdata[12:5], out_tdata[13], out_tdata[17:14], out_tlast);
        if (pending_results.size() == 0) begin
          $error("result with none expected: kind %0d slot %0d", got.kind, got.slot);
          fail_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got.kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, got.kind); fail_cnt++;
          end
          if (got.slot !== exp_r.slot) begin
            $error("slot_out: expected %0d, got %0d", exp_r.slot, got.slot); fail_cnt++;
          end
          if (got.ok !== exp_r.ok) begin
            $error("ok: expected %0d, got %0d", exp_r.ok, got.ok); fail_cnt++;
          end
          if (got.osc !== exp_r.osc) begin
            $error("is_osc: expected %0d, got %0d", exp_r.osc, got.osc); fail_cnt++;
          end
          if (got.pin !== exp_r.pin) begin
            $error("pin_out: expected %0d, got %0d", exp_r.pin, got.pin); fail_cnt++;
          end
          if (got.level !== exp_r.level) begin
            $error("level_out: expected %0d, got %0d", exp_r.level, got.level);
            fail_cnt++;
          end
          if (got.cnt !== exp_r.cnt) begin
            $error("count: expected %0d, got %0d", exp_r.cnt, got.cnt); fail_cnt++;
          end
          if (got.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, got.last); fail_cnt++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one command and predict it at the transfer. Valid stays high after
  // the transfer until the next command or idle cycle replaces it.
  task automatic send_cmd(input cmd_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, it.sel, it.lvl, it.pin, it.delay, it.reps, it.period, it.cmd};
    do @(posedge clk); while (!in_tready);
    predict_timer(it);
  endtask

  function automatic cmd_item_t mk_cmd(logic [2:0] c, logic [31:0] p, logic [15:0] r,
                                       logic [31:0] d, logic [7:0] pn, logic l,
                                       logic [2:0] s);
    cmd_item_t it;
    it = '{cmd: c, period: p, reps: r, delay: d, pin: pn, lvl: l, sel: s};
    return it;
  endfunction

  // Random command, mostly well-formed short-period timers and ticks.
  function automatic cmd_item_t rand_cmd();
    cmd_item_t it;
    int sel;
    it = mk_cmd(CMD_TICK, $urandom_range(6), 16'($signed($urandom_range(7)) - 2),
                32'($signed($urandom_range(8)) - 2), 8'($urandom), 1'($urandom),
                3'($urandom));
    if ($urandom_range(19) == 0) it.period = $urandom;
    if ($urandom_range(19) == 0) it.reps = 16'($urandom);
    if ($urandom_range(19) == 0) it.delay = $urandom;
    sel = $urandom_range(99);
    if (sel < 55) it.cmd = CMD_TICK;
    else if (sel < 72) it.cmd = CMD_SCHEDULE;
    else if (sel < 86) it.cmd = CMD_OSCILLATE;
    else if (sel < 95) it.cmd = CMD_REMOVE;
    else if (sel < 98) it.cmd = CMD_REMOVE_ALL;
    else it.cmd = 3'($urandom_range(7, 5));
    return it;
  endfunction

  // Stimulus.
  initial begin
    dir_row_t   rows[$];
    timer_res_t none_res;
    none_res = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    tm_now = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tm_used[i] = 0; tm_period[i] = 0; tm_due[i] = 0; tm_reps[i] = 0;
      tm_osc[i] = 0; tm_pin[i] = 0; tm_level[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; typed-in results only for the obvious rows.
    rows.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0), 1,
      mk_res(KIND_TICK_DONE, 0, 1, 0, 0, 0, 0, 1)});
    rows.push_back('{mk_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 3'd7), 1,
      mk_res(KIND_REMOVE_ACK, 7, 0, 0, 0, 0, 0, 1)});
    rows.push_back('{mk_cmd(CMD_SCHEDULE, 32'd2, 16'd0, 32'd0, 0, 0, 0), 1,
      mk_res(KIND_SCHED_ACK, 0, 1, 0, 0, 0, 0, 1)});
    rows.push_back('{mk_cmd(CMD_OSCILLATE, 32'd1, 16'd2, 32'hFFFF_FFFF, 8'hFF, 1, 0),
      1, mk_res(KIND_SCHED_ACK, 1, 1, 0, 0, 0, 0, 1)});
    rows.push_back('{mk_cmd(CMD_SCHEDULE, 32'hFFFF_FFFF, 16'h8000, 32'h7FFF_FFFF, 0,
      0, 0), 0, none_res});
    rows.push_back('{mk_cmd(CMD_SCHEDULE, 32'd3, 16'h7FFF, 32'hFFFF_FFFF, 0, 0, 0),
      0, none_res});
    rows.push_back('{mk_cmd(CMD_OSCILLATE, 32'd1, 16'hFFFF, 32'd1, 8'h00, 0, 0), 0,
      none_res});
    rows.push_back('{mk_cmd(CMD_SCHEDULE, 32'hFFFF_FFFF, 16'd1, 32'h8000_0000, 8'hAA,
      1, 3'd5), 0, none_res});
    rows.push_back('{mk_cmd(CMD_SCHEDULE, 32'd1, 16'hFFFF, 32'd0, 0, 0, 0), 0,
      none_res});
    rows.push_back('{mk_cmd(CMD_OSCILLATE, 32'd2, 16'd1, 32'd0, 8'h55, 1, 0), 0,
      none_res});
    // Table now full.
    rows.push_back('{mk_cmd(CMD_SCHEDULE, 32'd1, 16'd1, 32'd1, 0, 0, 0), 1,
      mk_res(KIND_SCHED_ACK, 0, 0, 0, 0, 0, 0, 1)});
    for (int k = 0; k < 4; k++)
      rows.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0), 0, none_res});
    rows.push_back('{mk_cmd(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1,
      3'd7), 0, none_res});
    rows.push_back('{mk_cmd(3'd7, 0, 0, 0, 0, 0, 0), 0, none_res});
    rows.push_back('{mk_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 3'd6), 0, none_res});
    rows.push_back('{mk_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 3'd4), 0, none_res});
    rows.push_back('{mk_cmd(CMD_REMOVE_ALL, 0, 0, 0, 0, 0, 0), 0, none_res});
    rows.push_back('{mk_cmd(CMD_REMOVE_ALL, 0, 0, 0, 0, 0, 0), 1,
      mk_res(KIND_RMALL_ACK, 0, 1, 0, 0, 0, 0, 1)});
    // Zero first delay: the slot is due right away.
    rows.push_back('{mk_cmd(CMD_SCHEDULE, 32'd5, 16'd0, 32'(-int'(0)) - 32'd0 + 32'd0,
      0, 0, 0), 0, none_res});
    rows.push_back('{mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0), 0, none_res});

    in_idle_pct = 28;
    out_idle_pct = 88;
    foreach (rows[r]) begin
      int before_len;
      before_len = pending_results.size();
      send_cmd(rows[r].item);
      if (rows[r].has_exp && pending_results.size() > before_len)
        pending_results[before_len] = rows[r].exp_res;
    end
    // Due time that wraps to zero: negative delay and a period equal to minus
    // the current time.
    send_cmd(mk_cmd(CMD_SCHEDULE, 32'd0 - tm_now, 16'd0, 32'hFFFF_FFFF, 0, 0, 0));
    send_cmd(mk_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0));

    // Random part in three idling phases.
    for (int n = 0; n < 196; n++) begin
      if (n == 65) begin in_idle_pct = 88; out_idle_pct = 28; end
      if (n == 130) begin in_idle_pct = 0; out_idle_pct = 0; end
      send_cmd(rand_cmd());
    end
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
